@@ rtl/ifc_pkg.sv @@
// Shared types, constants and helpers for the integer format converter.
package ifc_pkg;

    localparam int VALUE_W    = 32;
    localparam int FUNC_W     = 3;
    localparam int FW_W       = 7;
    localparam int PREC_W     = 6;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 7;
    localparam int NDIG_W     = 4;
    localparam int MAX_FIELD  = 64;
    localparam int MAX_PREC   = MAX_FIELD - 2;
    localparam int NUM_DIGITS = 11;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int REQ_W      = FUNC_W + VALUE_W + 5 + FW_W + PREC_W + 1;
    localparam int S_TDATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = CHAR_W;

    localparam logic [FUNC_W-1:0] FUNC_DEC  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_OCT  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEXL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_HEXU = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CHAR = 3'd4;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    // one request as it sits in s_tdata, func in the lowest bits
    typedef struct packed {
        logic                  precision_given;
        logic [PREC_W-1:0]     precision;
        logic [FW_W-1:0]       field_width;
        logic                  zero_pad;
        logic                  alternate_form;
        logic                  space_sign;
        logic                  force_plus;
        logic                  left_align;
        logic [VALUE_W-1:0]    value;
        logic [FUNC_W-1:0]     func;
    } req_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + CHAR_W'(d);
        end else begin
            digit_char = base + CHAR_W'(d - 4'd10);
        end
    endfunction

endpackage

@@ rtl/ifc_bcd_conv.sv @@
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
module ifc_bcd_conv (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ifc_pkg::VALUE_W-1:0] bin,
    output logic                       done,
    output logic [ifc_pkg::BCD_W-1:0]  bcd
);
    import ifc_pkg::*;

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BCD_W-1:0]     adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                       : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

@@ rtl/integer_format_converter_unit.sv @@
// Top level: printf-style integer and character conversion to an ASCII stream.
//
//  channel   dir  ports                         contents
//  s_        in   s_tvalid s_tready s_tdata     one conversion request
//  m_        out  m_tvalid m_tready m_tdata     one character, m_tlast on the final one
//
// Decimal runs through the shift-and-add-3 converter, one value bit a cycle;
// octal, hex and character take digits straight from the bits. N, the
// characters emitted, is 1 to 64, one per cycle while m_tready does not
// stall. A request with an unknown conversion code is dropped in the idle state.
// Reset clears the sequencer and the output valid; payload registers hold junk.
// s_tready is high only between requests; a stall on m_tready holds the
// character in the output register and freezes emission.
module integer_format_converter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[2:0] value[34:3] left_align[35] force_plus[36] space_sign[37]
    // alternate_form[38] zero_pad[39] field_width[46:40] precision[52:47]
    // precision_given[53], zero fill above
    input  logic [ifc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // char_out[7:0]
    output logic [ifc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import ifc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CONV,
        ST_PLAN,
        ST_SIZE,
        ST_EMIT
    } state_t;

    req_t req;
    assign req = req_t'(s_tdata[REQ_W-1:0]);

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                left_reg, left_next;
    logic                plus_reg, plus_next;
    logic                space_reg, space_next;
    logic                alt_reg, alt_next;
    logic                zpad_reg, zpad_next;
    logic                pgiven_reg, pgiven_next;
    logic [FW_W-1:0]     fw_reg, fw_next;
    logic [PREC_W-1:0]   prec_reg, prec_next;
    logic [3:0]          dig_reg [NUM_DIGITS];
    logic [3:0]          dig_next [NUM_DIGITS];
    logic [NDIG_W-1:0]   ndig_reg, ndig_next;
    logic [1:0]          npre_reg, npre_next;
    logic [CHAR_W-1:0]   pre0_reg, pre0_next;
    logic [CHAR_W-1:0]   pre1_reg, pre1_next;
    logic [LEN_W-1:0]    pz_reg, pz_next;
    logic [LEN_W-1:0]    body_reg, body_next;
    logic                zfill_reg, zfill_next;
    logic [LEN_W-1:0]    b1_reg, b1_next;
    logic [LEN_W-1:0]    b2_reg, b2_next;
    logic [LEN_W-1:0]    b3_reg, b3_next;
    logic [LEN_W-1:0]    b4_reg, b4_next;
    logic [LEN_W-1:0]    total_reg, total_next;
    logic [LEN_W-1:0]    pos_reg, pos_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;

    logic                bcd_start;
    logic                bcd_done;
    logic [BCD_W-1:0]    bcd;

    ifc_bcd_conv u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .bin     (mag_reg),
        .done    (bcd_done),
        .bcd     (bcd)
    );

    // digits straight from the magnitude bits, least significant first
    logic [4*NUM_DIGITS-1:0] magx;
    logic [3:0]              bits_dig [NUM_DIGITS];
    assign magx = (4*NUM_DIGITS)'(mag_reg);

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (func_reg == FUNC_OCT) begin
                bits_dig[i] = {1'b0, magx[3*i +: 3]};
            end else begin
                bits_dig[i] = (i < VALUE_W / 4) ? magx[4*i +: 4] : 4'd0;
            end
        end
    end

    // significant digit count, at least one
    logic [NDIG_W-1:0] ndig_c;
    always_comb begin
        ndig_c = NDIG_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (dig_reg[i] != 4'd0) begin
                ndig_c = NDIG_W'(i + 1);
            end
        end
    end

    logic              is_dec, is_hex, is_char, upper;
    logic [LEN_W-1:0]  pz_c;
    logic [LEN_W-1:0]  pad_c;
    logic [LEN_W-1:0]  pz_fill;
    logic [LEN_W-1:0]  lpad_c, rpad_c;
    logic [LEN_W-1:0]  dig_idx;
    logic [CHAR_W-1:0] emit_char;
    logic              out_free;
    logic              emit_last;

    assign is_dec  = (func_reg == FUNC_DEC);
    assign is_hex  = (func_reg == FUNC_HEXL) || (func_reg == FUNC_HEXU);
    assign is_char = (func_reg == FUNC_CHAR);
    assign upper   = (func_reg == FUNC_HEXU);

    // precision fill, then the octal leading zero when needed
    always_comb begin
        if (is_char) begin
            pz_c = '0;
        end else if (LEN_W'(prec_reg) > LEN_W'(ndig_c)) begin
            pz_c = LEN_W'(prec_reg) - LEN_W'(ndig_c);
        end else begin
            pz_c = '0;
        end
        if (alt_reg && (func_reg == FUNC_OCT) && (pz_c == '0) && (mag_reg != '0)) begin
            pz_c = LEN_W'(1);
        end
    end

    // width padding goes either to spaces or into the zero fill
    always_comb begin
        pad_c   = (LEN_W'(fw_reg) > body_reg) ? LEN_W'(fw_reg) - body_reg : '0;
        pz_fill = pz_reg;
        if (zfill_reg) begin
            pz_fill = pz_reg + pad_c;
            pad_c   = '0;
        end
        lpad_c = left_reg ? '0 : pad_c;
        rpad_c = left_reg ? pad_c : '0;
    end

    // character at the current position
    assign dig_idx = b4_reg - LEN_W'(1) - pos_reg;
    always_comb begin
        if (pos_reg < b1_reg) begin
            emit_char = CH_SPACE;
        end else if (pos_reg < b2_reg) begin
            emit_char = (pos_reg == b1_reg) ? pre0_reg : pre1_reg;
        end else if (pos_reg < b3_reg) begin
            emit_char = CH_ZERO;
        end else if (pos_reg < b4_reg) begin
            emit_char = is_char ? val_reg[CHAR_W-1:0]
                                : digit_char(dig_reg[dig_idx[NDIG_W-1:0]], upper);
        end else begin
            emit_char = CH_SPACE;
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = (pos_reg == total_reg - LEN_W'(1));
    assign bcd_start = (state_reg == ST_START) && is_dec;

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        val_next      = val_reg;
        mag_next      = mag_reg;
        left_next     = left_reg;
        plus_next     = plus_reg;
        space_next    = space_reg;
        alt_next      = alt_reg;
        zpad_next     = zpad_reg;
        pgiven_next   = pgiven_reg;
        fw_next       = fw_reg;
        prec_next     = prec_reg;
        dig_next      = dig_reg;
        ndig_next     = ndig_reg;
        npre_next     = npre_reg;
        pre0_next     = pre0_reg;
        pre1_next     = pre1_reg;
        pz_next       = pz_reg;
        body_next     = body_reg;
        zfill_next    = zfill_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        b3_next       = b3_reg;
        b4_next       = b4_reg;
        total_next    = total_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next   = req.func;
                    val_next    = req.value;
                    mag_next    = ((req.func == FUNC_DEC) && req.value[VALUE_W-1])
                                  ? VALUE_W'(0) - req.value : req.value;
                    left_next   = req.left_align;
                    plus_next   = req.force_plus;
                    space_next  = req.space_sign;
                    alt_next    = req.alternate_form;
                    zpad_next   = req.zero_pad;
                    pgiven_next = req.precision_given;
                    fw_next     = (req.field_width > FW_W'(MAX_FIELD))
                                  ? FW_W'(MAX_FIELD) : req.field_width;
                    prec_next   = (req.precision > PREC_W'(MAX_PREC))
                                  ? PREC_W'(MAX_PREC) : req.precision;
                    // unknown conversion codes produce no text
                    if (req.func <= FUNC_CHAR) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (is_dec) begin
                    state_next = ST_CONV;
                end else begin
                    dig_next   = bits_dig;
                    state_next = ST_PLAN;
                end
            end
            ST_CONV: begin
                if (bcd_done) begin
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        dig_next[i] = (i < BCD_DIGITS) ? bcd[4*i +: 4] : 4'd0;
                    end
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                ndig_next = is_char ? NDIG_W'(1) : ndig_c;
                npre_next = 2'd0;
                pre0_next = CH_ZERO;
                pre1_next = upper ? CH_UX : CH_LX;
                if (is_dec) begin
                    if (val_reg[VALUE_W-1]) begin
                        npre_next = 2'd1;
                        pre0_next = CH_MINUS;
                    end else if (plus_reg) begin
                        npre_next = 2'd1;
                        pre0_next = CH_PLUS;
                    end else if (space_reg) begin
                        npre_next = 2'd1;
                        pre0_next = CH_SPACE;
                    end
                end else if (is_hex && alt_reg && (val_reg != '0)) begin
                    npre_next = 2'd2;
                end
                pz_next    = pz_c;
                body_next  = LEN_W'(npre_next) + pz_c + LEN_W'(ndig_next);
                zfill_next = is_char ? (zpad_reg && !left_reg)
                                     : (zpad_reg && !left_reg && !pgiven_reg);
                state_next = ST_SIZE;
            end
            ST_SIZE: begin
                // segment ends: spaces | prefix | zeros | digits | spaces
                b1_next    = lpad_c;
                b2_next    = lpad_c + LEN_W'(npre_reg);
                b3_next    = lpad_c + LEN_W'(npre_reg) + pz_fill;
                b4_next    = lpad_c + LEN_W'(npre_reg) + pz_fill + LEN_W'(ndig_reg);
                total_next = lpad_c + LEN_W'(npre_reg) + pz_fill + LEN_W'(ndig_reg)
                             + rpad_c;
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = emit_char;
                    m_last_next   = emit_last;
                    pos_next      = pos_reg + LEN_W'(1);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        func_reg   <= func_next;
        val_reg    <= val_next;
        mag_reg    <= mag_next;
        left_reg   <= left_next;
        plus_reg   <= plus_next;
        space_reg  <= space_next;
        alt_reg    <= alt_next;
        zpad_reg   <= zpad_next;
        pgiven_reg <= pgiven_next;
        fw_reg     <= fw_next;
        prec_reg   <= prec_next;
        dig_reg    <= dig_next;
        ndig_reg   <= ndig_next;
        npre_reg   <= npre_next;
        pre0_reg   <= pre0_next;
        pre1_reg   <= pre1_next;
        pz_reg     <= pz_next;
        body_reg   <= body_next;
        zfill_reg  <= zfill_next;
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        b3_reg     <= b3_next;
        b4_reg     <= b4_next;
        total_reg  <= total_next;
        pos_reg    <= pos_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

    // a taken request with a known code closes the input until its text is out
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (req.func <= FUNC_CHAR) |=> !s_tready)
        else $error("input taken again right after a transfer");

    // emission never runs past the planned length
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (pos_reg < total_reg))
        else $error("emit position beyond text length");

    // text stays within the field limit and holds at least one digit
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (total_reg <= LEN_W'(MAX_FIELD)) && (ndig_reg != '0))
        else $error("text length out of bounds");

    // decimal converter only finishes while the sequencer waits for it
    a_bcd_done_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        bcd_done |-> (state_reg == ST_CONV))
        else $error("converter done outside of conversion wait");

endmodule

@@ bench/char_stream_checker.sv @@
// Checker for the integer format converter: predicts the character stream and compares it.
`timescale 1ns / 1ps

module char_stream_checker
    import ifc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   chars_pending,
    output int                   chars_checked
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_exp_t;

    char_exp_t expected_chars[$];

    initial begin
        fail_count    = 0;
        chars_pending = 0;
        chars_checked = 0;
    end

    task automatic report_mismatch(input string what);
        // print only the first few, but count every one
        if (fail_count < 30) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        fail_count = fail_count + 1;
    endtask

    // Formats one request and queues its characters, last flag on the final one.
    function automatic void format_conversion(input req_t r);
        int unsigned       fw, prec, npre, ndig, pz, body, pad, n, i, base;
        logic [CHAR_W-1:0] prefix[2];
        logic [CHAR_W-1:0] digits[32];
        logic [CHAR_W-1:0] text[128];
        logic [VALUE_W-1:0] mag;
        logic [3:0]        d;
        logic              upper, zero_fill;

        fw   = r.field_width;
        prec = r.precision;
        if (fw > MAX_FIELD) fw = MAX_FIELD;
        if (prec > MAX_PREC) prec = MAX_PREC;
        npre = 0;
        ndig = 0;
        pz   = 0;
        if (r.func > FUNC_CHAR) return;   // unknown code: dropped silently

        if (r.func == FUNC_CHAR) begin
            digits[0] = r.value[CHAR_W-1:0];
            ndig      = 1;
            zero_fill = r.zero_pad && !r.left_align;
        end else begin
            mag   = r.value;
            upper = (r.func == FUNC_HEXU);
            base  = (r.func == FUNC_DEC) ? 10 : ((r.func == FUNC_OCT) ? 8 : 16);
            if (r.func == FUNC_DEC) begin
                if (r.value[VALUE_W-1]) begin
                    mag = 32'd0 - r.value;
                    prefix[npre] = CH_MINUS;
                    npre = npre + 1;
                end else if (r.force_plus) begin
                    prefix[npre] = CH_PLUS;
                    npre = npre + 1;
                end else if (r.space_sign) begin
                    prefix[npre] = CH_SPACE;
                    npre = npre + 1;
                end
            end
            // least significant digit first
            do begin
                d = 4'(mag % base);
                if (d < 4'd10) begin
                    digits[ndig] = CH_ZERO + {4'd0, d};
                end else begin
                    digits[ndig] = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
                end
                ndig = ndig + 1;
                mag  = mag / base;
            end while (mag != 0);
            pz = (prec > ndig) ? prec - ndig : 0;
            if (r.alternate_form && r.func == FUNC_OCT && pz == 0
                    && digits[ndig-1] != CH_ZERO) begin
                pz = 1;
            end
            if (r.alternate_form && r.func >= FUNC_HEXL && r.value != 0) begin
                prefix[npre]     = CH_ZERO;
                prefix[npre + 1] = upper ? CH_UX : CH_LX;
                npre = npre + 2;
            end
            zero_fill = r.zero_pad && !r.left_align && !r.precision_given;
        end

        body = npre + pz + ndig;
        pad  = (fw > body) ? fw - body : 0;
        if (zero_fill) begin
            pz  = pz + pad;
            pad = 0;
        end

        n = 0;
        if (!r.left_align) begin
            for (i = 0; i < pad; i++) begin
                text[n] = CH_SPACE;
                n = n + 1;
            end
        end
        for (i = 0; i < npre; i++) begin
            text[n] = prefix[i];
            n = n + 1;
        end
        for (i = 0; i < pz; i++) begin
            text[n] = CH_ZERO;
            n = n + 1;
        end
        for (i = ndig; i > 0; i--) begin
            text[n] = digits[i-1];
            n = n + 1;
        end
        if (r.left_align) begin
            for (i = 0; i < pad; i++) begin
                text[n] = CH_SPACE;
                n = n + 1;
            end
        end
        for (i = 0; i < n; i++) begin
            expected_chars.push_back({text[i], i == n - 1});
        end
    endfunction

    always @(posedge aclk) begin
        char_exp_t exp_char;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h with nothing expected", m_tdata));
                end else begin
                    exp_char = expected_chars.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== exp_char.ch) begin
                        report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                                  m_tdata[CHAR_W-1:0], exp_char.ch));
                    end
                    if (m_tlast !== exp_char.last) begin
                        report_mismatch($sformatf("last %b, expected %b on char 0x%02h",
                                                  m_tlast, exp_char.last, exp_char.ch));
                    end
                end
                chars_checked <= chars_checked + 1;
            end
            if (s_tvalid && s_tready) begin
                format_conversion(s_tdata[REQ_W-1:0]);
            end
        end
        chars_pending <= expected_chars.size();
    end

endmodule

@@ bench/tb_integer_format_converter_unit.sv @@
// Testbench top for the integer format converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_integer_format_converter_unit;
    import ifc_pkg::*;

    // flow-control knobs
    localparam int IDLE_PCT      = 22;     // chance of an idle cycle per side
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int WATCHDOG_MAX  = 4000;   // cycles with no transfer at all
    localparam int DRAIN_CYCLES  = 120;    // covers the slowest decimal request
    localparam int RANDOM_ITEMS  = 400;    // random requests with a real code
    localparam logic [FUNC_W-1:0] FUNC_FIRST_UNKNOWN = FUNC_CHAR + 1'b1;
    localparam logic [FUNC_W-1:0] FUNC_LAST_UNKNOWN  = {FUNC_W{1'b1}};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int  fail_count, chars_pending, chars_checked;
    int  requests_sent  = 0;
    int  unknown_sent   = 0;
    int  idle_cycles    = 0;
    int  stall_asks     = 0;   // bumped by the sender to ask for a hold-off
    logic quiet_phase   = 1'b0; // no idling on either side while set

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    integer_format_converter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    char_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .chars_pending (chars_pending),
        .chars_checked (chars_checked)
    );

    // Watchdog: any transfer on either side resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("integer_format_converter_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever the sender asks.
    initial begin : receiver
        int stalls_served;
        stalls_served = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall_asks != stalls_served) begin
                stalls_served = stalls_served + 1;
                m_tready <= 1'b0;
                // counted here so the sender keeps offering requests meanwhile
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic req_t make_req(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] v,
                                      input logic la, input logic fp, input logic ss,
                                      input logic af, input logic zp,
                                      input logic [FW_W-1:0] fw, input logic [PREC_W-1:0] pr,
                                      input logic pg);
        req_t r;
        r.func            = fn;
        r.value           = v;
        r.left_align      = la;
        r.force_plus      = fp;
        r.space_sign      = ss;
        r.alternate_form  = af;
        r.zero_pad        = zp;
        r.field_width     = fw;
        r.precision       = pr;
        r.precision_given = pg;
        return r;
    endfunction

    // Mostly short fields so the run stays quick; a tail reaches the saturation limits.
    function automatic req_t random_req();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            r.func = FUNC_W'($urandom_range(FUNC_FIRST_UNKNOWN, FUNC_LAST_UNKNOWN));
        end else begin
            r.func = FUNC_W'($urandom_range(FUNC_DEC, FUNC_CHAR));
        end
        case ($urandom_range(0, 5))
            0: r.value = $urandom;
            1: r.value = $urandom_range(0, 20);
            2: r.value = 32'd0 - $urandom_range(1, 1000);
            3: begin
                case ($urandom_range(0, 4))
                    0: r.value = 32'h0000_0000;
                    1: r.value = 32'h0000_0001;
                    2: r.value = 32'hFFFF_FFFF;
                    3: r.value = 32'h7FFF_FFFF;
                    default: r.value = 32'h8000_0000;
                endcase
            end
            4: r.value = $urandom >> $urandom_range(0, 31);
            default: r.value = $urandom_range(32, 126);   // printable for %c
        endcase
        r.left_align     = 1'($urandom_range(0, 1));
        r.force_plus     = 1'($urandom_range(0, 1));
        r.space_sign     = 1'($urandom_range(0, 1));
        r.alternate_form = 1'($urandom_range(0, 1));
        r.zero_pad       = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 70) r.field_width = FW_W'($urandom_range(0, 16));
        else if (pick < 92) r.field_width = FW_W'($urandom_range(17, MAX_FIELD));
        else r.field_width = FW_W'($urandom_range(MAX_FIELD + 1, (1 << FW_W) - 1));
        pick = $urandom_range(0, 99);
        if (pick < 70) r.precision = PREC_W'($urandom_range(0, 12));
        else if (pick < 90) r.precision = PREC_W'($urandom_range(13, 40));
        else r.precision = PREC_W'($urandom_range(41, (1 << PREC_W) - 1));
        r.precision_given = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // One request transfer; s_tvalid stays high across back-to-back requests.
    task automatic send_request(input req_t r);
        while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - REQ_W){1'b0}}, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent = requests_sent + 1;
        if (r.func > FUNC_CHAR) unknown_sent = unknown_sent + 1;
    endtask

    task automatic wait_drained();
        // stop offering, then one edge so the checker has seen the last request transfer
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        req_t r;
        int   known_items;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every conversion, and the corner rules
        send_request(make_req(FUNC_DEC, 32'd0, 0, 0, 0, 0, 0, 7'd0, 6'd0, 0));
        send_request(make_req(FUNC_DEC, 32'h7FFF_FFFF, 0, 1, 0, 0, 0, 7'd0, 6'd0, 0));
        // most negative value, zero filled after the minus
        send_request(make_req(FUNC_DEC, 32'h8000_0000, 0, 0, 0, 0, 1, 7'd15, 6'd0, 0));
        send_request(make_req(FUNC_DEC, 32'd42, 0, 0, 1, 0, 0, 7'd0, 6'd0, 0));
        send_request(make_req(FUNC_DEC, 32'hFFFF_FFFB, 1, 0, 0, 0, 0, 7'd6, 6'd0, 1));
        // octal alternate form: zero value, plain, and already zero filled
        send_request(make_req(FUNC_OCT, 32'd0, 0, 0, 0, 1, 0, 7'd0, 6'd0, 0));
        send_request(make_req(FUNC_OCT, 32'd8, 0, 0, 0, 1, 0, 7'd0, 6'd0, 0));
        send_request(make_req(FUNC_OCT, 32'd8, 0, 0, 0, 1, 0, 7'd0, 6'd5, 1));
        send_request(make_req(FUNC_OCT, 32'hFFFF_FFFF, 0, 1, 1, 1, 0, 7'd0, 6'd0, 0));
        send_request(make_req(FUNC_HEXL, 32'hDEAD_BEEF, 0, 0, 0, 1, 1, 7'd20, 6'd0, 0));
        send_request(make_req(FUNC_HEXU, 32'hFFFF_FFFF, 0, 0, 0, 1, 0, 7'd0, 6'd0, 0));
        // hex zero: no prefix even with the alternate form
        send_request(make_req(FUNC_HEXL, 32'd0, 0, 0, 0, 1, 0, 7'd4, 6'd0, 0));
        // sign flags ignored outside decimal
        send_request(make_req(FUNC_HEXU, 32'h00AB_CDEF, 0, 1, 1, 0, 0, 7'd0, 6'd0, 0));
        send_request(make_req(FUNC_CHAR, 32'h0000_0041, 0, 0, 0, 0, 0, 7'd5, 6'd0, 0));
        // character: zero fill regardless of a given precision
        send_request(make_req(FUNC_CHAR, 32'hFFFF_FF41, 0, 1, 1, 1, 1, 7'd4, 6'd9, 1));
        send_request(make_req(FUNC_CHAR, 32'h0000_00FF, 1, 0, 0, 0, 1, 7'd3, 6'd0, 0));
        send_request(make_req(FUNC_CHAR, 32'h0000_0000, 0, 0, 0, 0, 0, 7'd0, 6'd0, 0));
        send_request(make_req(FUNC_LAST_UNKNOWN, 32'h1234_5678, 0, 0, 0, 0, 0, 7'd10, 6'd0, 0));
        send_request(make_req(FUNC_FIRST_UNKNOWN, 32'd1, 0, 0, 0, 0, 0, 7'd0, 6'd0, 0));
        // width and precision beyond their saturation points
        send_request(make_req(FUNC_DEC, 32'd1, 0, 0, 0, 0, 0, 7'd127, 6'd0, 0));
        send_request(make_req(FUNC_HEXL, 32'h0000_00FF, 0, 0, 0, 1, 0, 7'd0, 6'd63, 1));
        // left alignment wins over zero padding
        send_request(make_req(FUNC_DEC, 32'd123, 1, 1, 0, 0, 1, 7'd10, 6'd0, 0));
        // a given precision turns zero padding into spaces
        send_request(make_req(FUNC_DEC, 32'd77, 0, 0, 0, 0, 1, 7'd12, 6'd4, 1));
        send_request(make_req(FUNC_DEC, 32'h8000_0000, 0, 0, 0, 0, 0, 7'd64, 6'd62, 1));
        send_request(make_req(FUNC_OCT, 32'h8000_0000, 1, 0, 0, 1, 0, 7'd64, 6'd0, 0));

        // random: count only requests with a real conversion code
        known_items = 0;
        while (known_items < RANDOM_ITEMS) begin
            if (known_items == 100) begin
                stall_asks <= stall_asks + 1;   // receiver holds off, sender keeps going
            end
            if (known_items == 220) begin
                wait_drained();                 // sender pause until the block is empty
            end
            if (known_items == 260) quiet_phase <= 1'b1;
            if (known_items == 340) quiet_phase <= 1'b0;
            r = random_req();
            send_request(r);
            if (r.func <= FUNC_CHAR) known_items = known_items + 1;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d with unknown codes), %0d characters checked",
                 requests_sent, unknown_sent, chars_checked);
        $display("all five conversions, flag mixes, saturated widths, long receiver stall");
        if (fail_count == 0 && chars_pending == 0) begin
            $display("integer_format_converter_unit regression: pass");
        end else begin
            $display("integer_format_converter_unit regression: fail");
        end
        $finish;
    end

endmodule
